// File: rtl/core/ellipse_span_rasterizer_defines.svh
// assertion macros for the ellipse span rasterizer
`ifndef ELLIPSE_SPAN_RASTERIZER_DEFINES_SVH
`define ELLIPSE_SPAN_RASTERIZER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, reset masks the check
`define ESR_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define ESR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ESR_ASSERT_IMPL(lbl, ante, cons, msg)
`define ESR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/core/esr_pkg.sv
// shared types and constants of the ellipse span rasterizer
`timescale 1ns / 1ps

package esr_pkg;

	localparam int SCREEN_SIZE = 64;
	localparam logic signed [10:0] SCREEN_LAST = 11'(SCREEN_SIZE - 1);
	localparam logic [5:0] ROW_LAST = 6'(SCREEN_SIZE - 1);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	// one row of work for the back end
	typedef struct packed {
		logic [5:0] row;
		logic [7:0] ady;
		logic       last;
		logic       empty;
	} row_job_t;

	// per-ellipse values, held steady after setup while busy
	typedef struct packed {
		logic signed [9:0] cx;
		logic [15:0]       rx2;
		logic [15:0]       ry2;
		logic [15:0]       color;
	} shape_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_SETUP,
		F_GEN,
		F_DRAIN
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SQR_DY,
		B_RHS,
		B_SQ,
		B_CMP,
		B_EMIT
	} back_state_t;

endpackage

// File: rtl/core/ellipse_span_rasterizer.sv
// top level of the ellipse span rasterizer
//
// channel   direction  handshake             payload
// request   in         start & !busy         center_x center_y radius_x radius_y fill_color
// span      out        strobe (one cycle)    row span_start span_end span_color span_valid
//                                            last_span
//
// one request at a time: busy rises the cycle after start and falls after the last span.
// each row on screen passes through the back end as row setup, 8 bit steps of square,
// multiply and compare, and emit.
// the front end runs ahead through a 4-entry row queue; spans cannot be held off.
// arst_n clears all control state; the datapath registers are loaded before use.
`timescale 1ns / 1ps
`include "ellipse_span_rasterizer_defines.svh"

module ellipse_span_rasterizer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic signed [9:0] center_x,
	input  logic signed [9:0] center_y,
	input  logic [7:0]        radius_x,
	input  logic [7:0]        radius_y,
	input  logic [15:0]       fill_color,
	output logic              strobe,
	output logic [5:0]        row,
	output logic [5:0]        span_start,
	output logic [5:0]        span_end,
	output logic [15:0]       span_color,
	output logic              span_valid,
	output logic              last_span
);
	import esr_pkg::*;

	shape_t   shape;
	row_job_t push_job, head;
	logic     push, pop, q_full, q_empty, back_idle;

	esr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.center_x   (center_x),
		.center_y   (center_y),
		.radius_x   (radius_x),
		.radius_y   (radius_y),
		.fill_color (fill_color),
		.busy       (busy),
		.shape      (shape),
		.push       (push),
		.push_job   (push_job),
		.q_full     (q_full),
		.q_empty    (q_empty),
		.back_idle  (back_idle)
	);

	esr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	esr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.shape      (shape),
		.head       (head),
		.q_empty    (q_empty),
		.pop        (pop),
		.idle       (back_idle),
		.row        (row),
		.span_start (span_start),
		.span_end   (span_end),
		.span_color (span_color),
		.span_valid (span_valid),
		.last_span  (last_span),
		.strobe     (strobe)
	);

	`ESR_ASSERT_NEXT(a_strobe_single, strobe, !strobe, "span strobe held two cycles")
	`ESR_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request taken but not busy")
	`ESR_ASSERT_IMPL(a_no_span_idle, !busy, !strobe, "span emitted while idle")
	`ESR_ASSERT_IMPL(a_hidden_zero, strobe && !span_valid,
		span_start == 6'd0 && span_end == 6'd0, "hidden span has nonzero columns")

endmodule

// File: rtl/core/esr_front.sv
// front end: takes the ellipse request, finds the visible rows, queues row jobs
`timescale 1ns / 1ps

module esr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic signed [9:0] center_x,
	input  logic signed [9:0] center_y,
	input  logic [7:0]        radius_x,
	input  logic [7:0]        radius_y,
	input  logic [15:0]       fill_color,
	output logic              busy,
	output esr_pkg::shape_t   shape,
	output logic              push,
	output esr_pkg::row_job_t push_job,
	input  logic              q_full,
	input  logic              q_empty,
	input  logic              back_idle
);
	import esr_pkg::*;

	front_state_t state_q, state_d;

	logic signed [9:0] cx_q, cy_q;
	logic [7:0]        rx_q, ry_q;
	logic [15:0]       color_q, rx2_q, ry2_q;
	logic [5:0]        row_q, row_hi_q;
	logic              empty_q;

	logic signed [10:0] top_s, bot_s, dy;
	logic [10:0]        ady_w;
	logic               empty_c, job_last;
	logic [5:0]         row_lo_c, row_hi_c;

	// row range of the ellipse clipped to the screen
	always_comb begin
		top_s = $signed({cy_q[9], cy_q}) - $signed({3'b000, ry_q});
		bot_s = $signed({cy_q[9], cy_q}) + $signed({3'b000, ry_q});
		empty_c = (rx_q == 8'd0) || (ry_q == 8'd0) || (top_s > SCREEN_LAST) ||
			(bot_s < 11'sd0);
		row_lo_c = (top_s < 11'sd0) ? 6'd0 : top_s[5:0];
		row_hi_c = (bot_s > SCREEN_LAST) ? ROW_LAST : bot_s[5:0];
	end

	always_comb begin
		dy = $signed({5'b00000, row_q}) - $signed({cy_q[9], cy_q});
		ady_w = (dy < 11'sd0) ? 11'(-dy) : 11'(dy);
		job_last = empty_q || (row_q == row_hi_q);
		push_job.row = empty_q ? 6'd0 : row_q;
		push_job.ady = ady_w[7:0];
		push_job.last = job_last;
		push_job.empty = empty_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (start) state_d = F_SETUP;
			end
			F_SETUP: state_d = F_GEN;
			F_GEN: begin
				if (!q_full && job_last) state_d = F_DRAIN;
			end
			F_DRAIN: begin
				if (q_empty && back_idle) state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != F_IDLE);
		push = (state_q == F_GEN) && !q_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && start) begin
			cx_q <= center_x;
			cy_q <= center_y;
			rx_q <= radius_x;
			ry_q <= radius_y;
			color_q <= fill_color;
		end
		if (state_q == F_SETUP) begin
			rx2_q <= 16'(rx_q * rx_q);
			ry2_q <= 16'(ry_q * ry_q);
			row_q <= row_lo_c;
			row_hi_q <= row_hi_c;
			empty_q <= empty_c;
		end
		if (push && !job_last) begin
			row_q <= row_q + 6'd1;
		end
	end

	assign shape.cx = cx_q;
	assign shape.rx2 = rx2_q;
	assign shape.ry2 = ry2_q;
	assign shape.color = color_q;

endmodule

// File: rtl/core/esr_queue.sv
// short fifo of row jobs between front and back end
`timescale 1ns / 1ps

module esr_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  esr_pkg::row_job_t push_job,
	input  logic              pop,
	output esr_pkg::row_job_t head,
	output logic              full,
	output logic              empty
);
	import esr_pkg::*;

	row_job_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_q, rd_q;
	logic [QPTR_W:0]     count_q;

	assign full = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// File: rtl/core/esr_back.sv
// back end: bit-serial half width search per row, clipping and span output
`timescale 1ns / 1ps

module esr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  esr_pkg::shape_t   shape,
	input  esr_pkg::row_job_t head,
	input  logic              q_empty,
	output logic              pop,
	output logic              idle,
	output logic [5:0]        row,
	output logic [5:0]        span_start,
	output logic [5:0]        span_end,
	output logic [15:0]       span_color,
	output logic              span_valid,
	output logic              last_span,
	output logic              strobe
);
	import esr_pkg::*;

	back_state_t state_q, state_d;

	row_job_t    job_q;
	logic [15:0] ady2_q, sq_q;
	logic [31:0] rhs_q;
	logic [7:0]  h_q;
	logic [2:0]  bit_q;
	logic        strobe_q;

	logic [5:0]  row_q, start_q, end_q;
	logic [15:0] color_q;
	logic        valid_q, last_q;

	logic [7:0]         cand;
	logic [31:0]        prod;
	logic signed [10:0] left_s, right_s;
	logic               off_screen;

	always_comb begin
		cand = h_q | (8'd1 << bit_q);
		prod = 32'(sq_q) * 32'(shape.ry2);
		left_s = $signed({shape.cx[9], shape.cx}) - $signed({3'b000, h_q});
		right_s = $signed({shape.cx[9], shape.cx}) + $signed({3'b000, h_q});
		off_screen = job_q.empty || (right_s < 11'sd0) || (left_s > SCREEN_LAST);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!q_empty) state_d = head.empty ? B_EMIT : B_SQR_DY;
			end
			B_SQR_DY: state_d = B_RHS;
			B_RHS: state_d = B_SQ;
			B_SQ: state_d = B_CMP;
			B_CMP: state_d = (bit_q == 3'd0) ? B_EMIT : B_SQ;
			B_EMIT: state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop = (state_q == B_IDLE) && !q_empty;
		idle = (state_q == B_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			strobe_q <= 1'b0;
		end else begin
			state_q <= state_d;
			strobe_q <= (state_q == B_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				job_q <= head;
				h_q <= 8'd0;
				bit_q <= 3'd7;
			end
			B_SQR_DY: ady2_q <= 16'(job_q.ady * job_q.ady);
			// ady never exceeds ry, so the difference stays non-negative
			B_RHS: rhs_q <= 32'(shape.rx2) * 32'(shape.ry2 - ady2_q);
			B_SQ: sq_q <= {8'd0, cand} * {8'd0, cand};
			B_CMP: begin
				if (prod <= rhs_q) h_q <= cand;
				bit_q <= bit_q - 3'd1;
			end
			B_EMIT: begin
				row_q <= job_q.row;
				color_q <= shape.color;
				last_q <= job_q.last;
				valid_q <= !off_screen;
				if (off_screen) begin
					start_q <= 6'd0;
					end_q <= 6'd0;
				end else begin
					start_q <= (left_s < 11'sd0) ? 6'd0 : left_s[5:0];
					end_q <= (right_s > SCREEN_LAST) ? ROW_LAST : right_s[5:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign row = row_q;
	assign span_start = start_q;
	assign span_end = end_q;
	assign span_color = color_q;
	assign span_valid = valid_q;
	assign last_span = last_q;
	assign strobe = strobe_q;

endmodule
